FILE: rtl/core/sty_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sty_pkg
// Shared types and defaults for the sorted year table: command codes, the
// control word broadcast to every cell and the link passed between cells.
// ----------------------------------------------------------------------------
package sty_pkg;

  localparam int DEF_TABLE_DEPTH  = 64;
  localparam int DEF_YEAR_BITS    = 16;
  localparam int DEF_PAYLOAD_BITS = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // broadcast to all cells during the execute cycle
  typedef struct packed {
    logic go;    // execute cycle, hit flags are refreshed
    logic ins;   // insert into a table that is not full
    logic find;
    logic rd;
  } cell_ctrl_t;

  // handed from a cell to its right-hand neighbour
  typedef struct packed {
    logic greater;  // valid entry with year above the key
    logic match;    // valid entry with year equal to the key
  } link_t;

endpackage

FILE: rtl/core/sty_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sty_cell
// One table slot. Holds a year and payload, compares against the broadcast
// key and shifts right on insert when its left neighbour is larger.
// ----------------------------------------------------------------------------
module sty_cell #(
  parameter int INDEX        = 0,
  parameter int IDX_W        = 6,
  parameter int CNT_W        = 7,
  parameter int YEAR_BITS    = sty_pkg::DEF_YEAR_BITS,
  parameter int PAYLOAD_BITS = sty_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sty_pkg::cell_ctrl_t            ctrl,
  input  logic signed [YEAR_BITS-1:0]    key,
  input  logic [PAYLOAD_BITS-1:0]        tag,
  input  logic [IDX_W-1:0]               pos,
  input  logic [CNT_W-1:0]               count,
  input  sty_pkg::link_t                 link_in,
  input  logic signed [YEAR_BITS-1:0]    left_year,
  input  logic [PAYLOAD_BITS-1:0]        left_payload,
  output sty_pkg::link_t                 link_out,
  output logic signed [YEAR_BITS-1:0]    year,
  output logic [PAYLOAD_BITS-1:0]        payload,
  output logic                           hit
);

  logic valid;
  logic at_end;
  logic greater;
  logic match;

  assign valid   = CNT_W'(INDEX) < count;
  assign at_end  = CNT_W'(INDEX) == count;
  assign greater = valid && (year > key);
  assign match   = valid && (year == key);

  assign link_out.greater = greater;
  assign link_out.match   = match;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (link_in.greater) begin
        year    <= left_year;
        payload <= left_payload;
      end else if (greater || at_end) begin
        year    <= key;
        payload <= tag;
      end
    end
  end

  // sorted, so the first match is the one whose left neighbour misses
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.go) begin
      hit <= (ctrl.find && match && !link_in.match) ||
             (ctrl.rd && valid && (pos == IDX_W'(INDEX)));
    end
  end

endmodule

FILE: rtl/core/sty_collect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sty_collect
// Gathers the single hit cell (if any) into one result: index, year and
// payload, by OR of the masked cell outputs.
// ----------------------------------------------------------------------------
module sty_collect #(
  parameter int TABLE_DEPTH  = sty_pkg::DEF_TABLE_DEPTH,
  parameter int IDX_W        = 6,
  parameter int YEAR_BITS    = sty_pkg::DEF_YEAR_BITS,
  parameter int PAYLOAD_BITS = sty_pkg::DEF_PAYLOAD_BITS
) (
  input  logic [TABLE_DEPTH-1:0]         hit_vec,
  input  logic [YEAR_BITS-1:0]           years [TABLE_DEPTH],
  input  logic [PAYLOAD_BITS-1:0]        payloads [TABLE_DEPTH],
  output logic                           any_hit,
  output logic [IDX_W-1:0]               hit_index,
  output logic [YEAR_BITS-1:0]           hit_year,
  output logic [PAYLOAD_BITS-1:0]        hit_payload
);

  always_comb begin
    hit_index   = '0;
    hit_year    = '0;
    hit_payload = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_index   = hit_index   | ({IDX_W{hit_vec[i]}} & IDX_W'(i));
      hit_year    = hit_year    | ({YEAR_BITS{hit_vec[i]}} & years[i]);
      hit_payload = hit_payload | ({PAYLOAD_BITS{hit_vec[i]}} & payloads[i]);
    end
  end

  assign any_hit = |hit_vec;

endmodule

FILE: rtl/core/sorted_year_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_year_table
// Table of (year, payload) entries kept in ascending signed year order.
//
// Input channel (in_valid / in_stall): one command word per item, cmd
// selects insert, find, read or clear. Output channel (out_valid /
// out_stall): exactly one result word per command.
// Each command passes the steps capture, execute in the cell row and gather
// of the hit cell into the output register. The next command is taken
// only once the gather is done, so a new word is not accepted while one
// is still in progress.
// Insert shifts every larger entry one cell right in the execute cycle;
// find and read mark at most one cell, which the gather picks up.
// A full table drops an insert and flags full_drop.
// If the receiver stalls, the result holds in the output register; one
// further command may be taken and executed, then waits in the gather
// step until the output register frees.
// Reset empties the table and clears both channels; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_year_table #(
  parameter int TABLE_DEPTH  = sty_pkg::DEF_TABLE_DEPTH,
  parameter int YEAR_BITS    = sty_pkg::DEF_YEAR_BITS,
  parameter int PAYLOAD_BITS = sty_pkg::DEF_PAYLOAD_BITS,
  localparam int IDX_W       = $clog2(TABLE_DEPTH),
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic signed [YEAR_BITS-1:0]    year_key,
  input  logic [PAYLOAD_BITS-1:0]        payload_tag,
  input  logic [IDX_W-1:0]               position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [IDX_W-1:0]               match_index,
  output logic signed [YEAR_BITS-1:0]    year_out,
  output logic [PAYLOAD_BITS-1:0]        payload_out,
  output logic [CNT_W-1:0]               entry_total,
  output logic                           full_drop
);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_EXEC    = 3'b010,
    S_COLLECT = 3'b100
  } state_t;

  state_t state, state_next;

  logic                        in_take;
  logic                        out_free;
  logic [1:0]                  cmd_q;
  logic signed [YEAR_BITS-1:0] key_q;
  logic [PAYLOAD_BITS-1:0]     tag_q;
  logic [IDX_W-1:0]            pos_q;
  logic [CNT_W-1:0]            count;
  logic                        is_full;
  logic                        drop_q;
  sty_pkg::cell_ctrl_t         ctrl;

  sty_pkg::link_t              links [TABLE_DEPTH];
  sty_pkg::link_t              tail_link;
  logic [YEAR_BITS-1:0]        years [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0]     payloads [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      hit_vec;

  logic                        any_hit;
  logic [IDX_W-1:0]            hit_index;
  logic [YEAR_BITS-1:0]        hit_year;
  logic [PAYLOAD_BITS-1:0]     hit_payload;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign is_full  = (count == CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_EXEC;
      S_EXEC:    state_next = S_COLLECT;
      S_COLLECT: if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q <= cmd;
      key_q <= year_key;
      tag_q <= payload_tag;
      pos_q <= position;
    end
  end

  always_comb begin
    ctrl.go   = (state == S_EXEC);
    ctrl.ins  = ctrl.go && (cmd_q == sty_pkg::CMD_INSERT) && !is_full;
    ctrl.find = (cmd_q == sty_pkg::CMD_FIND);
    ctrl.rd   = (cmd_q == sty_pkg::CMD_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      drop_q <= 1'b0;
    end else if (ctrl.go) begin
      drop_q <= (cmd_q == sty_pkg::CMD_INSERT) && is_full;
      if (ctrl.ins) begin
        count <= count + CNT_W'(1);
      end else if (cmd_q == sty_pkg::CMD_CLEAR) begin
        count <= '0;
      end
    end
  end

  // row of cells, each linked to its left neighbour
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sty_pkg::link_t              lnk_in;
    sty_pkg::link_t              lnk_out;
    logic signed [YEAR_BITS-1:0] l_year;
    logic [PAYLOAD_BITS-1:0]     l_payload;
    logic signed [YEAR_BITS-1:0] c_year;

    if (i == 0) begin : g_head
      assign lnk_in    = '0;
      assign l_year    = key_q;
      assign l_payload = tag_q;
    end else begin : g_body
      assign lnk_in    = links[i-1];
      assign l_year    = years[i-1];
      assign l_payload = payloads[i-1];
    end

    sty_cell #(
      .INDEX        (i),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W),
      .YEAR_BITS    (YEAR_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .key          (key_q),
      .tag          (tag_q),
      .pos          (pos_q),
      .count        (count),
      .link_in      (lnk_in),
      .left_year    (l_year),
      .left_payload (l_payload),
      .link_out     (lnk_out),
      .year         (c_year),
      .payload      (payloads[i]),
      .hit          (hit_vec[i])
    );

    assign links[i] = lnk_out;
    assign years[i] = c_year;
  end

  assign tail_link = links[TABLE_DEPTH-1];

  sty_collect #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .IDX_W        (IDX_W),
    .YEAR_BITS    (YEAR_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_collect (
    .hit_vec     (hit_vec),
    .years       (years),
    .payloads    (payloads),
    .any_hit     (any_hit),
    .hit_index   (hit_index),
    .hit_year    (hit_year),
    .hit_payload (hit_payload)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_COLLECT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_COLLECT && out_free) begin
      found       <= any_hit;
      match_index <= hit_index;
      year_out    <= hit_year;
      payload_out <= hit_payload;
      entry_total <= count;
      full_drop   <= drop_q;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_single_hit : assert property (@(posedge clk) disable iff (rst)
    state == S_COLLECT |-> $onehot0(hit_vec))
    else $error("more than one cell marked");

  a_tail_shift : assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |-> !tail_link.greater)
    else $error("insert would push an entry off the end");

  a_drop_full : assert property (@(posedge clk) disable iff (rst)
    out_valid && full_drop |-> entry_total == CNT_W'(TABLE_DEPTH))
    else $error("drop flagged on a table that is not full");

  a_hit_below_count : assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> CNT_W'(match_index) < entry_total)
    else $error("hit index beyond entry count");

  a_take_exec : assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == S_EXEC)
    else $error("accepted word not executed");

endmodule
